FILE: hw/rtl/i2cm_pkg.sv
// Package for the I2C master bit engine: payload structs, phase encoding,
// configuration register indexes and reset values. No dependencies.
package i2cm_pkg;

	localparam int HalfWidth    = 8;
	localparam int HoldWidth    = 8;
	localparam int TimeoutWidth = 10;
	localparam int CfgIdxWidth  = 2;
	localparam int CfgDataWidth = 10;

	localparam logic [HalfWidth-1:0]    HalfReset    = 8'd4;
	localparam logic [HoldWidth-1:0]    HoldReset    = 8'd12;
	localparam logic [TimeoutWidth-1:0] TimeoutReset = 10'd250;
	localparam logic [3:0]              BitsPerByte  = 4'd8;

	typedef enum logic [CfgIdxWidth-1:0] {
		CFG_HALF_PERIOD = 2'd0,
		CFG_START_HOLD  = 2'd1,
		CFG_ACK_TIMEOUT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_SEND  = 3'd3,
		OP_WACK  = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_START_A   = 4'd1,
		PH_START_B   = 4'd2,
		PH_STOP_LO   = 4'd3,
		PH_STOP_HI   = 4'd4,
		PH_STOP_END  = 4'd5,
		PH_SEND_LO   = 4'd6,
		PH_SEND_HI   = 4'd7,
		PH_READ_LO   = 4'd8,
		PH_READ_HI   = 4'd9,
		PH_RACK_LO   = 4'd10,
		PH_RACK_HI   = 4'd11,
		PH_WACK_LO   = 4'd12,
		PH_WACK_HI   = 4'd13,
		PH_WACK_POLL = 4'd14
	} phase_t;

	typedef struct packed {
		logic       cmd_valid;
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} out_item_t;

	typedef struct packed {
		logic [HalfWidth-1:0]    half_period_ticks;
		logic [HoldWidth-1:0]    start_hold_ticks;
		logic [TimeoutWidth-1:0] ack_timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic scl;
		logic drv;
		logic sda;
	} line_t;

	// A released SDA line always reads back as high.
	function automatic line_t mk_line(logic scl, logic drv, logic sda);
		line_t l;
		l.scl = scl;
		l.drv = drv;
		l.sda = drv ? sda : 1'b1;
		return l;
	endfunction

endpackage

FILE: hw/rtl/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: configuration registers, input
// handshake and result register. Depends on i2cm_pkg and i2cm_core.
//
// Each input beat is one timing tick carrying an optional command and the
// sampled SDA level; each accepted tick yields exactly one result beat with
// the SCL/SDA line state, busy, done, the last received byte and the
// acknowledge-failure flag. A beat is taken when valid is high and stall is
// low on its channel.
// A tick's result appears on the output in the cycle after it is accepted.
// One tick is accepted per cycle when not stalled; the sequencer state
// register and the result register are the only storage in the path.
// When the receiver stalls a pending result, the input is stalled in the
// same cycle and the held result stays unchanged until it is taken.
// The configuration channel is always ready; writes to an index beyond the
// three registers are dropped. Reset clears the sequencer to idle with SCL
// high and SDA driven high, and loads the default tick counts.
module i2c_master_bit_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  i2cm_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output i2cm_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [i2cm_pkg::CfgIdxWidth-1:0]  cfg_index,
	input  logic [i2cm_pkg::CfgDataWidth-1:0] cfg_data
);
	import i2cm_pkg::*;

	cfg_t      cfg_q;
	out_item_t res;
	out_item_t out_data_q;
	logic      out_valid_q;
	logic      accept;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period_ticks <= HalfReset;
			cfg_q.start_hold_ticks  <= HoldReset;
			cfg_q.ack_timeout_ticks <= TimeoutReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_data[HalfWidth-1:0];
				CFG_START_HOLD:  cfg_q.start_hold_ticks  <= cfg_data[HoldWidth-1:0];
				CFG_ACK_TIMEOUT: cfg_q.ack_timeout_ticks <= cfg_data[TimeoutWidth-1:0];
				default: begin
				end
			endcase
		end
	end

	i2cm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (in_data),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: hw/rtl/i2cm_core.sv
// Bit sequencer of the I2C master: phase, counters and line state, advanced
// once per accepted tick. Depends on i2cm_pkg.
module i2cm_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  i2cm_pkg::in_item_t  item,
	input  i2cm_pkg::cfg_t      cfg,
	output i2cm_pkg::out_item_t res
);
	import i2cm_pkg::*;

	phase_t      phase_q, n_phase;
	logic [3:0]  bit_index_q, n_bit_index;
	logic [7:0]  shift_q, n_shift;
	logic [7:0]  delay_q, n_delay;
	logic [TimeoutWidth-1:0] timeout_q, n_timeout;
	logic        ack_choice_q, n_ack_choice;
	line_t       line_q, n_line;
	logic [7:0]  rx_q, n_rx;
	logic        failed_q, n_failed;
	logic        saf_q, n_saf;
	logic        done;
	logic [3:0]  bit_inc;
	logic [7:0]  shift_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_index_q  <= '0;
			shift_q      <= '0;
			delay_q      <= '0;
			timeout_q    <= '0;
			ack_choice_q <= 1'b0;
			line_q       <= '{scl: 1'b1, drv: 1'b1, sda: 1'b1};
			rx_q         <= '0;
			failed_q     <= 1'b0;
			saf_q        <= 1'b0;
		end else if (step) begin
			phase_q      <= n_phase;
			bit_index_q  <= n_bit_index;
			shift_q      <= n_shift;
			delay_q      <= n_delay;
			timeout_q    <= n_timeout;
			ack_choice_q <= n_ack_choice;
			line_q       <= n_line;
			rx_q         <= n_rx;
			failed_q     <= n_failed;
			saf_q        <= n_saf;
		end
	end

	assign bit_inc  = bit_index_q + 4'd1;
	assign shift_sh = {shift_q[6:0], 1'b0};

	always_comb begin
		n_phase      = phase_q;
		n_bit_index  = bit_index_q;
		n_shift      = shift_q;
		n_delay      = delay_q;
		n_timeout    = timeout_q;
		n_ack_choice = ack_choice_q;
		n_line       = line_q;
		n_rx         = rx_q;
		n_failed     = failed_q;
		n_saf        = saf_q;
		done         = 1'b0;

		if (phase_q == PH_IDLE) begin
			if (item.cmd_valid && item.op >= OP_START && item.op <= OP_READ) begin
				n_failed    = 1'b0;
				n_saf       = 1'b0;
				n_bit_index = '0;
				unique case (item.op)
					OP_START: begin
						n_phase = PH_START_A;
						n_delay = cfg.start_hold_ticks;
						n_line  = mk_line(1'b1, 1'b1, 1'b1);
					end
					OP_STOP: begin
						n_phase = PH_STOP_LO;
						n_delay = cfg.half_period_ticks;
						n_line  = mk_line(1'b0, 1'b1, 1'b0);
					end
					OP_SEND: begin
						n_shift = item.tx_byte;
						n_phase = PH_SEND_LO;
						n_delay = cfg.half_period_ticks;
						n_line  = mk_line(1'b0, 1'b1, item.tx_byte[7]);
					end
					OP_WACK: begin
						n_phase = PH_WACK_LO;
						n_delay = cfg.half_period_ticks;
						n_line  = mk_line(1'b0, 1'b0, 1'b1);
					end
					default: begin
						n_ack_choice = item.send_ack;
						n_shift      = '0;
						n_phase      = PH_READ_LO;
						n_delay      = cfg.half_period_ticks;
						n_line       = mk_line(1'b0, 1'b0, 1'b1);
					end
				endcase
			end
		end else if (phase_q == PH_WACK_POLL) begin
			if (!item.sda_in) begin
				n_timeout  = '0;
				n_phase    = PH_IDLE;
				n_delay    = '0;
				n_line.scl = 1'b0;
				done       = 1'b1;
			end else if (timeout_q >= cfg.ack_timeout_ticks) begin
				n_timeout = '0;
				n_saf     = 1'b1;
				n_phase   = PH_STOP_LO;
				n_delay   = cfg.half_period_ticks;
				n_line    = mk_line(1'b0, 1'b1, 1'b0);
			end else begin
				n_timeout = timeout_q + TimeoutWidth'(1);
			end
		end else if (delay_q > 8'd1) begin
			n_delay = delay_q - 8'd1;
		end else if (phase_q == PH_READ_LO) begin
			n_phase = PH_READ_HI;
			n_delay = cfg.half_period_ticks;
			n_line  = mk_line(1'b1, 1'b0, 1'b1);
			n_shift = {shift_q[6:0], item.sda_in};
		end else begin
			unique case (phase_q)
				PH_START_A: begin
					n_phase = PH_START_B;
					n_delay = cfg.start_hold_ticks;
					n_line  = mk_line(1'b1, 1'b1, 1'b0);
				end
				PH_STOP_LO: begin
					n_phase = PH_STOP_HI;
					n_delay = cfg.start_hold_ticks;
					n_line  = mk_line(1'b1, 1'b1, 1'b0);
				end
				PH_STOP_HI: begin
					n_phase = PH_STOP_END;
					n_delay = cfg.start_hold_ticks;
					n_line  = mk_line(1'b1, 1'b1, 1'b1);
				end
				PH_STOP_END: begin
					if (saf_q) begin
						n_failed = 1'b1;
					end
					n_saf      = 1'b0;
					n_phase    = PH_IDLE;
					n_delay    = '0;
					n_line.scl = 1'b1;
					done       = 1'b1;
				end
				PH_SEND_LO: begin
					n_phase = PH_SEND_HI;
					n_delay = cfg.half_period_ticks;
					n_line  = mk_line(1'b1, 1'b1, line_q.sda);
				end
				PH_SEND_HI: begin
					n_bit_index = bit_inc;
					if (bit_inc >= BitsPerByte) begin
						n_phase    = PH_IDLE;
						n_delay    = '0;
						n_line.scl = 1'b0;
						done       = 1'b1;
					end else begin
						n_shift = shift_sh;
						n_phase = PH_SEND_LO;
						n_delay = cfg.half_period_ticks;
						n_line  = mk_line(1'b0, 1'b1, shift_sh[7]);
					end
				end
				PH_READ_HI: begin
					n_bit_index = bit_inc;
					n_delay     = cfg.half_period_ticks;
					if (bit_inc >= BitsPerByte) begin
						n_rx    = shift_q;
						n_phase = PH_RACK_LO;
						n_line  = mk_line(1'b0, 1'b1, ~ack_choice_q);
					end else begin
						n_phase = PH_READ_LO;
						n_line  = mk_line(1'b0, 1'b0, 1'b1);
					end
				end
				PH_RACK_LO: begin
					n_phase = PH_RACK_HI;
					n_delay = cfg.half_period_ticks;
					n_line  = mk_line(1'b1, 1'b1, line_q.sda);
				end
				PH_START_B, PH_RACK_HI: begin
					n_phase    = PH_IDLE;
					n_delay    = '0;
					n_line.scl = 1'b0;
					done       = 1'b1;
				end
				PH_WACK_LO: begin
					n_phase = PH_WACK_HI;
					n_delay = cfg.half_period_ticks;
					n_line  = mk_line(1'b1, 1'b0, 1'b1);
				end
				PH_WACK_HI: begin
					n_phase   = PH_WACK_POLL;
					n_delay   = '0;
					n_line    = mk_line(1'b1, 1'b0, 1'b1);
					n_timeout = '0;
				end
				default: begin
					n_phase = PH_IDLE;
					n_delay = '0;
				end
			endcase
		end
	end

	always_comb begin
		res.scl_level  = n_line.scl;
		res.sda_level  = n_line.sda;
		res.sda_drive  = n_line.drv;
		res.busy_res   = (n_phase != PH_IDLE);
		res.done_res   = done;
		res.rx_byte    = n_rx;
		res.ack_failed = n_failed;
	end

endmodule

FILE: hw/rtl/i2cm_checker.sv
// Port-level checks for the I2C master bit engine, bound to its top level.
// Depends on i2cm_pkg and i2c_master_bit_engine.
module i2cm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input i2cm_pkg::out_item_t out_data
);
	import i2cm_pkg::*;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.done_res && out_data.busy_res))
		else $error("done and busy shown on the same beat");

	a_released_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.sda_drive) |-> out_data.sda_level)
		else $error("released SDA not reported high");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while result register can take a beat");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled result beat changed");

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (.*);
